// ===== rtl/core/mme_pkg.sv =====
package mme_pkg;

	// modulus after reset: 131 * 2^19 + 1, cut to the value width at the top level
	localparam logic [63:0] MODULUS_RESET = 64'd68681729;

	// status of the bit-serial modular multiplier
	typedef struct packed {
		logic busy;
		logic done;
	} mme_mul_stat_t;

endpackage

// ===== rtl/core/mme_modmul.sv =====
module mme_modmul #(
	parameter int W = 62
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [W-1:0]          a,
	input  logic [W-1:0]          b,
	input  logic [W-1:0]          m,
	output logic [W-1:0]          result,
	output mme_pkg::mme_mul_stat_t stat
);
	import mme_pkg::*;

	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  acc_q;
	logic [W-1:0]  mplr_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [W+1:0]  sum;
	logic [W+2:0]  diff1;
	logic [W+2:0]  diff2;
	logic [W-1:0]  acc_next;

	// double, add on a set multiplier bit, then one of three reductions
	always_comb begin
		sum   = {1'b0, acc_q, 1'b0} + (mplr_q[W-1] ? {2'b00, a} : {(W+2){1'b0}});
		diff1 = {1'b0, sum} - {3'b000, m};
		diff2 = {1'b0, sum} - {2'b00, m, 1'b0};
		priority if (!diff2[W+2]) begin
			acc_next = diff2[W-1:0];
		end else if (!diff1[W+2]) begin
			acc_next = diff1[W-1:0];
		end else begin
			acc_next = sum[W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q  <= '0;
			mplr_q <= b;
		end else if (busy_q) begin
			acc_q  <= acc_next;
			mplr_q <= mplr_q << 1;
		end
	end

	assign result    = acc_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ===== rtl/core/modular_exponentiation.sv =====
// channel   direction  handshake                 payload
// input     in         start, accepted when !busy  base, exponent
// result    out        done, one-cycle strobe      power
// config    in         modulus_we                  modulus_wdata
//
// one item at a time; busy is high from acceptance until the result strobe, except for a zero exponent or modulus
// each modular product runs in the shared bit-serial multiplier
// an item reduces its base, skips leading exponent zeros, then squares (and multiplies) per
// exponent bit from the top set bit; a zero exponent or a zero modulus gives its result in
// the cycle after acceptance
// arst_n clears control and loads the modulus reset value; the receiver cannot stall
module modular_exponentiation #(
	parameter int VALUE_WIDTH = 62,
	parameter int EXP_WIDTH   = 63
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [VALUE_WIDTH-1:0] base,
	input  logic [EXP_WIDTH-1:0]   exponent,
	output logic                   done,
	output logic [VALUE_WIDTH-1:0] power,
	input  logic                   modulus_we,
	input  logic [VALUE_WIDTH-1:0] modulus_wdata
);
	import mme_pkg::*;

	localparam int VW = VALUE_WIDTH;
	localparam int EW = EXP_WIDTH;
	localparam int CW = $clog2(EW + 1);

	// reduce base, skip leading zeros, then square (and multiply) per bit
	typedef enum logic [2:0] {
		S_IDLE,
		S_REDUCE,
		S_SKIP,
		S_SQUARE,
		S_MULT
	} state_t;

	state_t        state_q;
	logic [VW-1:0] mod_q;
	logic [VW-1:0] base_q;     // raw base, then base mod modulus
	logic [EW-1:0] exp_q;      // exponent, shifted left one bit per step
	logic [CW-1:0] exp_cnt_q;  // exponent bits still to scan
	logic [VW-1:0] res_q;
	logic [VW-1:0] power_q;
	logic          done_q;
	logic          go_q;

	logic [VW-1:0]  one_m;
	logic           exp_end;
	logic [VW-1:0]  mul_a;
	logic [VW-1:0]  mul_b;
	logic [VW-1:0]  mul_res;
	mme_mul_stat_t  mul_stat;

	// 1 mod modulus
	assign one_m   = {{(VW-1){1'b0}}, (mod_q != VW'(1))};
	assign exp_end = (exp_cnt_q == CW'(1));

	// multiplier operands, held steady while a product runs
	always_comb begin
		unique case (state_q)
			S_REDUCE: begin
				mul_a = one_m;
				mul_b = base_q;
			end
			S_SQUARE: begin
				mul_a = res_q;
				mul_b = res_q;
			end
			S_MULT: begin
				mul_a = base_q;
				mul_b = res_q;
			end
			default: begin
				mul_a = res_q;
				mul_b = res_q;
			end
		endcase
	end

	mme_modmul #(
		.W(VW)
	) u_modmul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (go_q),
		.a      (mul_a),
		.b      (mul_b),
		.m      (mod_q),
		.result (mul_res),
		.stat   (mul_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			mod_q     <= MODULUS_RESET[VW-1:0];
			base_q    <= '0;
			exp_q     <= '0;
			exp_cnt_q <= '0;
			res_q     <= '0;
			power_q   <= '0;
			done_q    <= 1'b0;
			go_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			go_q   <= 1'b0;
			if (modulus_we) begin
				mod_q <= modulus_wdata;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (exponent == '0) begin
							// zero exponent gives exactly 1, whatever the modulus
							power_q <= VW'(1);
							done_q  <= 1'b1;
						end else if (mod_q == '0) begin
							power_q <= '0;
							done_q  <= 1'b1;
						end else begin
							base_q    <= base;
							exp_q     <= exponent;
							exp_cnt_q <= CW'(EW);
							res_q     <= one_m;
							go_q      <= 1'b1;
							state_q   <= S_REDUCE;
						end
					end
				end
				S_REDUCE: begin
					if (mul_stat.done) begin
						base_q  <= mul_res;
						state_q <= S_SKIP;
					end
				end
				S_SKIP: begin
					if (exp_q[EW-1]) begin
						go_q    <= 1'b1;
						state_q <= S_SQUARE;
					end else begin
						exp_q     <= exp_q << 1;
						exp_cnt_q <= exp_cnt_q - CW'(1);
					end
				end
				S_SQUARE, S_MULT: begin
					if (mul_stat.done) begin
						res_q <= mul_res;
						if (state_q == S_SQUARE && exp_q[EW-1]) begin
							go_q    <= 1'b1;
							state_q <= S_MULT;
						end else if (exp_end) begin
							power_q <= mul_res;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							exp_q     <= exp_q << 1;
							exp_cnt_q <= exp_cnt_q - CW'(1);
							go_q      <= 1'b1;
							state_q   <= S_SQUARE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy  = (state_q != S_IDLE);
	assign done  = done_q;
	assign power = power_q;

`ifndef SYNTHESIS
	// zero exponent answers 1 in the next cycle
	a_zero_exp: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && exponent == '0) |=> (done && power == VW'(1)))
		else $error("zero exponent did not give 1");

	// multiplier only runs in a product state
	a_mul_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_stat.busy |-> (state_q == S_REDUCE || state_q == S_SQUARE || state_q == S_MULT))
		else $error("multiplier running outside a product state");

	// the result strobe leaves the block ready for the next item
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while still busy");

	// work only starts from an accepted item
	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy without an accepted item");
`endif

endmodule

// ===== sim/modular_exponentiation_tb.sv =====
`timescale 1ns / 1ps

module modular_exponentiation_tb;
	import mme_pkg::*;

	localparam int VW = 62;
	localparam int EW = 63;

	typedef logic [VW-1:0] value_t;
	typedef logic [EW-1:0] exp_t;

	localparam value_t RST_MOD = value_t'(MODULUS_RESET);
	localparam value_t ALL_V   = {VW{1'b1}};
	localparam value_t ALL_V_M1 = {{(VW-1){1'b1}}, 1'b0};
	localparam exp_t   ALL_E   = {EW{1'b1}};
	localparam exp_t   TOP_E   = {1'b1, {(EW-1){1'b0}}};

	// one directed row: modulus to run under, the item, and a typed-in power where obvious
	typedef struct packed {
		value_t modv;
		value_t b;
		exp_t   e;
		logic   typed;
		value_t pw;
	} vector_t;

	localparam int N_DIRECTED = 21;

	vector_t directed_rows [N_DIRECTED] = '{
		'{RST_MOD, 62'd2, 63'd0, 1'b1, 62'd1},          // after reset, zero exponent
		'{RST_MOD, 62'd3, 63'd1, 1'b1, 62'd3},
		'{RST_MOD, 62'd0, 63'd5, 1'b1, 62'd0},
		'{RST_MOD, RST_MOD, 63'd1, 1'b1, 62'd0},        // base equal to the modulus
		'{RST_MOD, 62'd2, 63'd10, 1'b1, 62'd1024},
		'{RST_MOD, ALL_V, 63'd1, 1'b0, 62'd0},
		'{RST_MOD, 62'd7, ALL_E, 1'b0, 62'd0},          // longest exponent
		'{62'd1, 62'd5, 63'd0, 1'b1, 62'd1},            // modulus of one, zero exponent
		'{62'd1, 62'd5, 63'd3, 1'b1, 62'd0},
		'{62'd1, ALL_V, ALL_E, 1'b1, 62'd0},
		'{ALL_V, ALL_V_M1, 63'd2, 1'b1, 62'd1},         // (-1)^2
		'{ALL_V, ALL_V, 63'd7, 1'b1, 62'd0},
		'{ALL_V, ALL_V_M1, ALL_E, 1'b1, ALL_V_M1},      // (-1)^odd
		'{ALL_V, 62'd3, TOP_E, 1'b0, 62'd0},
		'{62'd0, 62'd5, 63'd0, 1'b1, 62'd1},            // modulus of zero
		'{62'd0, 62'd5, 63'd9, 1'b1, 62'd0},
		'{62'd0, ALL_V, ALL_E, 1'b1, 62'd0},
		'{62'd2, 62'd3, 63'd100, 1'b1, 62'd1},
		'{62'd97, 62'd5, 63'd96, 1'b0, 62'd0},
		'{62'h2000_0000_0000_0000, ALL_V, 63'd2, 1'b0, 62'd0},
		'{RST_MOD, 62'd123456789, 63'h1234_5678_9ABC, 1'b0, 62'd0}
	};

	logic   clk           = 1'b0;
	logic   arst_n        = 1'b0;
	logic   start         = 1'b0;
	logic   busy;
	value_t base          = '0;
	exp_t   exponent      = '0;
	logic   done;
	value_t power;
	logic   modulus_we    = 1'b0;
	value_t modulus_wdata = '0;

	value_t cur_modulus = RST_MOD;   // our copy of the modulus register
	value_t awaited_power [$];       // powers of accepted items, oldest first
	int mismatches    = 0;
	int items_sent    = 0;
	int results_seen  = 0;
	int moduli_loaded = 0;

	modular_exponentiation #(
		.VALUE_WIDTH(VW),
		.EXP_WIDTH  (EW)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.base         (base),
		.exponent     (exponent),
		.done         (done),
		.power        (power),
		.modulus_we   (modulus_we),
		.modulus_wdata(modulus_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// left-to-right square and multiply; products are exact in double width
	function automatic value_t modpow(input value_t m, input value_t b, input exp_t e);
		logic [2*VW-1:0] acc;
		logic [2*VW-1:0] bb;
		if (e == '0)
			return value_t'(1);
		if (m == '0)
			return '0;
		bb  = b % m;
		acc = 1 % m;
		// leading zero bits only square 1 (or 0 when m is 1), so scan every bit
		for (int i = EW - 1; i >= 0; i--) begin
			acc = (acc * acc) % m;
			if (e[i])
				acc = (acc * bb) % m;
		end
		return value_t'(acc);
	endfunction

	function automatic logic [63:0] wide_random();
		return {$urandom, $urandom};
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t ns: %s", $time, what);
		mismatches++;
	endtask

	// caller is at a falling edge; start stays high after return so the next item can follow
	task automatic issue_item(input value_t b, input exp_t e, input logic typed,
			input value_t pw);
		start    <= 1'b1;
		base     <= b;
		exponent <= e;
		do
			@(posedge clk);
		while (busy);
		awaited_power.insert(awaited_power.size(), typed ? pw : modpow(cur_modulus, b, e));
		items_sent++;
		@(negedge clk);
	endtask

	// random sender gap: none half the time, some short, a few long
	task automatic pause_sender(input bit quiet);
		int k;
		int g;
		k = $urandom_range(0, 15);
		if (quiet || k < 8)
			g = 0;
		else if (k < 14)
			g = $urandom_range(1, 4);
		else
			g = $urandom_range(20, 80);
		if (g > 0) begin
			start <= 1'b0;
			repeat (g) @(negedge clk);
		end
	endtask

	// modulus writes only once the block has drained
	task automatic load_modulus(input value_t m);
		start <= 1'b0;
		while (awaited_power.size() != 0 || busy)
			@(negedge clk);
		modulus_we    <= 1'b1;
		modulus_wdata <= m;
		@(negedge clk);
		modulus_we  <= 1'b0;
		cur_modulus = m;
		moduli_loaded++;
	endtask

	// result check: done is a one-cycle strobe, nothing can hold it off
	always @(posedge clk) begin
		value_t want;
		if (arst_n && done) begin
			if (awaited_power.size() == 0) begin
				report_mismatch($sformatf("power %h with no item outstanding", power));
			end else begin
				want = awaited_power.pop_front();
				results_seen++;
				if (power !== want)
					report_mismatch($sformatf("power %h, expected %h", power, want));
			end
		end
	end

	initial begin
		value_t m;
		value_t b;
		exp_t   e;
		int     k;
		int     w;
		bit     quiet;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed rows: extremes, modulus of one and zero, base at or above the modulus
		for (int r = 0; r < N_DIRECTED; r++) begin
			if (directed_rows[r].modv != cur_modulus)
				load_modulus(directed_rows[r].modv);
			pause_sender(1'b0);
			issue_item(directed_rows[r].b, directed_rows[r].e, directed_rows[r].typed,
				directed_rows[r].pw);
		end

		// random phases, each under its own modulus
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: m = ALL_V;
				1: m = value_t'(1);
				2: m = value_t'(2);
				3: m = RST_MOD;
				default: begin
					w = $urandom_range(1, VW);
					m = value_t'(wide_random()) & value_t'((64'd1 << w) - 1);
					m[w-1] = 1'b1;
				end
			endcase
			load_modulus(m);
			quiet = (p % 3 == 0);   // some phases run back to back
			for (int n = 0; n < 10; n++) begin
				k = $urandom_range(0, 7);
				case (k)
					0: b = value_t'($urandom_range(0, 20));
					1: b = ALL_V;
					2: b = m - 1;
					3: b = m;
					default: b = value_t'(wide_random());
				endcase
				// mostly short exponents keep the run short; a few span the full width
				k = $urandom_range(0, 9);
				if (k == 0)
					e = '0;
				else if (k == 1)
					e = exp_t'(wide_random());
				else begin
					w = $urandom_range(1, 12);
					e = exp_t'(wide_random()) & exp_t'((64'd1 << w) - 1);
				end
				pause_sender(quiet);
				issue_item(b, e, 1'b0, '0);
			end
		end

		start <= 1'b0;
		while (awaited_power.size() != 0)
			@(negedge clk);
		// watch for stray strobes after the last result
		repeat (200) @(negedge clk);

		$display("ran %0d items (%0d directed) under %0d modulus writes, %0d results checked",
			items_sent, N_DIRECTED, moduli_loaded, results_seen);
		$display("covered zero exponent, moduli 0, 1, 2 and all ones, full-width operands");
		if (mismatches == 0 && awaited_power.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, awaited_power.size());
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#40_000_000;
		$display("timeout: %0d results still outstanding", awaited_power.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
